// ===== rtl/core/jms_pkg.sv =====
// Shared types, marker codes and helpers for the JPEG marker segmenter.
`timescale 1ns / 1ps

package jms_pkg;

  // Parse modes, one-hot
  typedef enum logic [6:0] {
    MODE_HDR_HI  = 7'b0000001,
    MODE_HDR_LO  = 7'b0000010,
    MODE_LEN_HI  = 7'b0000100,
    MODE_LEN_LO  = 7'b0001000,
    MODE_BODY    = 7'b0010000,
    MODE_SCAN    = 7'b0100000,
    MODE_SCAN_FF = 7'b1000000
  } mode_t;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_CLOSE   = 1'b1;

  localparam logic [15:0] MRK_SOI  = 16'hFFD8;
  localparam logic [15:0] MRK_EOI  = 16'hFFD9;
  localparam logic [15:0] MRK_RST0 = 16'hFFD0;
  localparam logic [15:0] MRK_RST7 = 16'hFFD7;
  localparam logic [15:0] MRK_TEM  = 16'hFF01;
  localparam logic [15:0] MRK_SOS  = 16'hFFDA;

  localparam logic [7:0] BYTE_FILL   = 8'hFF;
  localparam logic [7:0] BYTE_STUFF  = 8'h00;
  localparam logic [7:0] BYTE_RST_LO = 8'hD0;
  localparam logic [7:0] BYTE_RST_HI = 8'hD7;

  // Most results one input byte can cause
  localparam int unsigned MAX_RES = 3;

  typedef struct packed {
    logic        kind;
    logic [15:0] segment_header;
    logic [7:0]  byte_value;
    logic        run_end;
  } res_t;

  function automatic logic is_standalone(input logic [15:0] hdr);
    return (hdr == MRK_SOI) || (hdr == MRK_EOI) || (hdr == MRK_TEM) ||
           ((hdr >= MRK_RST0) && (hdr <= MRK_RST7));
  endfunction

  // Second byte of a pair that stays inside the entropy data
  function automatic logic is_scan_pair(input logic [7:0] b);
    return (b == BYTE_STUFF) || ((b >= BYTE_RST_LO) && (b <= BYTE_RST_HI));
  endfunction

  function automatic res_t mk_res(input logic kind, input logic [15:0] hdr,
                                  input logic [7:0] val);
    res_t r;
    r.kind           = kind;
    r.segment_header = hdr;
    r.byte_value     = val;
    r.run_end        = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/core/jms_byte_if.sv =====
// Byte input channel of the JPEG marker segmenter.
`timescale 1ns / 1ps

interface jms_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

// ===== rtl/core/jms_result_if.sv =====
// Result channel of the JPEG marker segmenter.
`timescale 1ns / 1ps

interface jms_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] segment_header;
  logic [7:0]  byte_value;
  logic        run_end;

  modport source (output valid, output kind, output segment_header, output byte_value,
                  output run_end, input ready);
  modport sink (input valid, input kind, input segment_header, input byte_value,
                input run_end, output ready);
endinterface

// ===== rtl/core/jpeg_marker_segmenter.sv =====
// Top level: splits a JPEG byte stream into marker segments.
//
//   channel   dir  transaction        payload
//   in_byte   in   one file byte      data_byte[7:0], final_byte
//   out_res   out  one result item    kind, segment_header[15:0], byte_value[7:0], run_end
//
// Each accepted byte is parsed in the cycle it is taken and yields zero to three results,
// written together into a three-entry result register that drains one per cycle while
// out_res is ready. A byte with more than one result holds the input until the result
// register holds only its last entry and that entry is being taken.
// Reset (rst_n low, synchronous) returns the parser to waiting for a header and empties
// the result register. A stall on out_res holds the results and, while any result
// waits, holds in_byte too.
`timescale 1ns / 1ps

module jpeg_marker_segmenter (
  input  logic              clk,
  input  logic              rst_n,
  jms_byte_if.sink          in_byte,
  jms_result_if.source      out_res
);

  jms_pkg::mode_t mode_r, mode_nxt;
  logic [7:0]     header_high_r, header_high_nxt;
  logic [15:0]    cur_hdr_r, cur_hdr_nxt;
  logic [7:0]     len_high_r, len_high_nxt;
  logic [15:0]    remain_r, remain_nxt;

  jms_pkg::res_t  res_r [jms_pkg::MAX_RES];
  jms_pkg::res_t  slot_nxt [jms_pkg::MAX_RES];
  logic [1:0]     cnt_r;
  logic [1:0]     n_nxt;

  logic           in_acc, out_acc;
  logic [7:0]     b;
  logic           fin;
  logic           open_en;
  logic [15:0]    open_hdr;
  logic [15:0]    len;
  logic [15:0]    rem_dec;

  assign b   = in_byte.data_byte;
  assign fin = in_byte.final_byte;

  // Take a byte when the result register is empty or its last entry leaves now
  assign in_byte.ready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_res.ready);
  assign in_acc        = in_byte.valid && in_byte.ready;
  assign out_acc       = out_res.valid && out_res.ready;

  assign out_res.valid          = (cnt_r != 2'd0);
  assign out_res.kind           = res_r[0].kind;
  assign out_res.segment_header = res_r[0].segment_header;
  assign out_res.byte_value     = res_r[0].byte_value;
  assign out_res.run_end        = res_r[0].run_end;

  assign len     = {len_high_r, b};
  assign rem_dec = remain_r - {15'd0, (remain_r != 16'd0)};

  always_comb begin
    mode_nxt        = mode_r;
    header_high_nxt = header_high_r;
    cur_hdr_nxt     = cur_hdr_r;
    len_high_nxt    = len_high_r;
    remain_nxt      = remain_r;
    open_en         = 1'b0;
    open_hdr        = {header_high_r, b};
    n_nxt           = 2'd0;
    for (int i = 0; i < jms_pkg::MAX_RES; i++) begin
      slot_nxt[i] = '0;
    end

    unique case (mode_r)
      jms_pkg::MODE_HDR_LO: begin
        open_en  = 1'b1;
        open_hdr = {header_high_r, b};
      end
      jms_pkg::MODE_LEN_HI: begin
        len_high_nxt = b;
        mode_nxt     = jms_pkg::MODE_LEN_LO;
      end
      jms_pkg::MODE_LEN_LO: begin
        slot_nxt[0] = jms_pkg::mk_res(jms_pkg::KIND_PAYLOAD, cur_hdr_r, len_high_r);
        slot_nxt[1] = jms_pkg::mk_res(jms_pkg::KIND_PAYLOAD, cur_hdr_r, b);
        n_nxt       = 2'd2;
        if (len <= 16'd2) begin
          mode_nxt = jms_pkg::MODE_HDR_HI;
        end else begin
          remain_nxt = len - 16'd2;
          mode_nxt   = jms_pkg::MODE_BODY;
        end
        if ((len <= 16'd2) || fin) begin
          slot_nxt[2] = jms_pkg::mk_res(jms_pkg::KIND_CLOSE, cur_hdr_r, 8'd0);
          n_nxt       = 2'd3;
        end
      end
      jms_pkg::MODE_BODY: begin
        slot_nxt[0] = jms_pkg::mk_res(jms_pkg::KIND_PAYLOAD, cur_hdr_r, b);
        n_nxt       = 2'd1;
        remain_nxt  = rem_dec;
        if ((rem_dec == 16'd0) || fin) begin
          slot_nxt[1] = jms_pkg::mk_res(jms_pkg::KIND_CLOSE, cur_hdr_r, 8'd0);
          n_nxt       = 2'd2;
          mode_nxt    = jms_pkg::MODE_HDR_HI;
        end
      end
      jms_pkg::MODE_SCAN: begin
        if (b == jms_pkg::BYTE_FILL) begin
          mode_nxt = jms_pkg::MODE_SCAN_FF;
        end else begin
          slot_nxt[n_nxt] = jms_pkg::mk_res(jms_pkg::KIND_PAYLOAD, cur_hdr_r, b);
          n_nxt           = n_nxt + 2'd1;
        end
        if (fin) begin
          slot_nxt[n_nxt] = jms_pkg::mk_res(jms_pkg::KIND_CLOSE, cur_hdr_r, 8'd0);
          n_nxt           = n_nxt + 2'd1;
        end
      end
      jms_pkg::MODE_SCAN_FF: begin
        if (b == jms_pkg::BYTE_FILL) begin
          // Extra fill byte: emit one 0xFF, keep the pending one
          slot_nxt[0] = jms_pkg::mk_res(jms_pkg::KIND_PAYLOAD, cur_hdr_r,
                                        jms_pkg::BYTE_FILL);
          n_nxt       = 2'd1;
          if (fin) begin
            slot_nxt[1] = jms_pkg::mk_res(jms_pkg::KIND_CLOSE, cur_hdr_r, 8'd0);
            n_nxt       = 2'd2;
          end
        end else if (jms_pkg::is_scan_pair(b)) begin
          slot_nxt[0] = jms_pkg::mk_res(jms_pkg::KIND_PAYLOAD, cur_hdr_r,
                                        jms_pkg::BYTE_FILL);
          slot_nxt[1] = jms_pkg::mk_res(jms_pkg::KIND_PAYLOAD, cur_hdr_r, b);
          n_nxt       = 2'd2;
          mode_nxt    = jms_pkg::MODE_SCAN;
          if (fin) begin
            slot_nxt[2] = jms_pkg::mk_res(jms_pkg::KIND_CLOSE, cur_hdr_r, 8'd0);
            n_nxt       = 2'd3;
          end
        end else begin
          // Real marker: close the scan, then treat the pair as the next header
          slot_nxt[0] = jms_pkg::mk_res(jms_pkg::KIND_CLOSE, cur_hdr_r, 8'd0);
          n_nxt       = 2'd1;
          open_en     = 1'b1;
          open_hdr    = {jms_pkg::BYTE_FILL, b};
        end
      end
      default: begin
        header_high_nxt = b;
        mode_nxt        = jms_pkg::MODE_HDR_LO;
      end
    endcase

    if (open_en) begin
      cur_hdr_nxt = open_hdr;
      if (jms_pkg::is_standalone(open_hdr)) begin
        slot_nxt[n_nxt] = jms_pkg::mk_res(jms_pkg::KIND_CLOSE, open_hdr, 8'd0);
        n_nxt           = n_nxt + 2'd1;
        mode_nxt        = jms_pkg::MODE_HDR_HI;
      end else if (open_hdr == jms_pkg::MRK_SOS) begin
        mode_nxt = jms_pkg::MODE_SCAN;
        if (fin) begin
          slot_nxt[n_nxt] = jms_pkg::mk_res(jms_pkg::KIND_CLOSE, open_hdr, 8'd0);
          n_nxt           = n_nxt + 2'd1;
        end
      end else begin
        mode_nxt = jms_pkg::MODE_LEN_HI;
      end
    end

    if (fin) begin
      mode_nxt = jms_pkg::MODE_HDR_HI;
    end

    // Flag the last result of this byte
    if (n_nxt != 2'd0) begin
      slot_nxt[n_nxt - 2'd1].run_end = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= jms_pkg::MODE_HDR_HI;
      header_high_r <= '0;
      cur_hdr_r     <= '0;
      len_high_r    <= '0;
      remain_r      <= '0;
    end else if (in_acc) begin
      mode_r        <= mode_nxt;
      header_high_r <= header_high_nxt;
      cur_hdr_r     <= cur_hdr_nxt;
      len_high_r    <= len_high_nxt;
      remain_r      <= remain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (in_acc) begin
      cnt_r <= n_nxt;
    end else if (out_acc) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // Load a fresh set of results, or advance the queue by one
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < jms_pkg::MAX_RES; i++) begin
        res_r[i] <= slot_nxt[i];
      end
    end else if (out_acc) begin
      for (int i = 0; i < jms_pkg::MAX_RES - 1; i++) begin
        res_r[i] <= res_r[i + 1];
      end
    end
  end

endmodule

// ===== rtl/core/jms_checker.sv =====
// Port-level checks for the JPEG marker segmenter, bound to its top level.
`timescale 1ns / 1ps

module jms_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [7:0]  out_byte_value,
  input logic        out_run_end
);

  // Hold a result until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  // A segment close carries no byte
  a_close_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == jms_pkg::KIND_CLOSE)) |-> (out_byte_value == 8'd0))
    else $error("close result with nonzero byte");

  // Input is held back only while results wait
  a_ready_only_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

  // More results of the same byte follow directly
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_run_end) |=> out_valid)
    else $error("run ended without run_end");

  // Input ready while results of an unfinished run remain would mix runs
  a_no_mix: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && out_valid) |-> (out_ready && out_run_end))
    else $error("byte accepted before previous run drained");

endmodule

bind jpeg_marker_segmenter jms_checker u_jms_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_byte.valid),
  .in_ready       (in_byte.ready),
  .out_valid      (out_res.valid),
  .out_ready      (out_res.ready),
  .out_kind       (out_res.kind),
  .out_byte_value (out_res.byte_value),
  .out_run_end    (out_res.run_end)
);
